>>> rtl/rfmc_pkg.sv
// Shared types, constants and CRC32C helpers for the record framer.
package rfmc_pkg;

   localparam int LEN_BITS_DEF = 32;
   localparam int LEN_FIELD_W  = 32;
   localparam int Q_DEPTH      = 4;
   localparam int ROT_R        = 15;

   localparam logic [31:0] CRC_POLY   = 32'h82F63B78;
   localparam logic [31:0] CRC_ONES   = 32'hFFFFFFFF;
   localparam logic [31:0] MASK_DELTA = 32'hA282EAD8;

   typedef struct packed {
      logic                   hdr;
      logic                   empty;
      logic                   last;
      logic [7:0]             pbyte;
      logic [LEN_FIELD_W-1:0] len;
      logic [31:0]            crc;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   function automatic logic [31:0] mask_crc(input logic [31:0] raw);
      logic [31:0] c;
      c = ~raw;
      return {c[ROT_R-1:0], c[31:ROT_R]} + MASK_DELTA;
   endfunction

endpackage

>>> rtl/record_framer_masked_crc32c_core.sv
// Top level of the record framer with masked CRC32C length and data checks.
// A request is held in a queue entry, then the back end's current entry, then the output byte register.
// Throughput: one response byte per cycle from the back-end sequencer while rsp_tready is high; a first
// request of a record yields 13 bytes (16 when empty, 17 for one byte), a later one 1 byte (5 on the last).
// A 4-entry queue lets requests flow in at one per cycle, until it is full, while the back end drains.
// Reset: synchronous, active high; clears record position, queue and output valid.
module record_framer_masked_crc32c_core #(
   parameter int LEN_BITS = rfmc_pkg::LEN_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [7:0] payload_byte, [39:8] record_length
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic        rsp_tlast,   // end_of_record
   output logic        rsp_tuser    // [0] end_of_item
);
   import rfmc_pkg::*;

   qstat_type q_stat;
   entry_type q_entry;
   entry_type q_head;
   logic      q_push;
   logic      q_pop;

   rfmc_front #(
      .LEN_BITS (LEN_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_stat     (q_stat),
      .q_push     (q_push),
      .q_entry    (q_entry)
   );

   rfmc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .head       (q_head),
      .stat       (q_stat)
   );

   rfmc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_stat     (q_stat),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_stat.full))
      else $error("queue push while full");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      !(q_pop && q_stat.empty))
      else $error("queue pop while empty");

   a_eor_eoi: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> rsp_tuser)
      else $error("end of record without end of item");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && !q_pop))
      else $error("output active after reset");

endmodule

>>> rtl/rfmc_front.sv
// Front end: accepts requests, tracks record position and payload CRC, builds queue entries.
module rfmc_front #(
   parameter int LEN_BITS = rfmc_pkg::LEN_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [39:0]           req_tdata,
   input  rfmc_pkg::qstat_type   q_stat,
   output logic                  q_push,
   output rfmc_pkg::entry_type   q_entry
);
   import rfmc_pkg::*;

   localparam int LenW = (LEN_BITS < LEN_FIELD_W) ? LEN_BITS : LEN_FIELD_W;

   logic            inside_ff, inside_in;
   logic [LenW-1:0] remain_ff, remain_in;
   logic [31:0]     crc_ff, crc_in;
   logic [31:0]     crc_new;
   logic [LenW-1:0] len;
   logic [7:0]      pb;
   logic            accept;
   logic            is_empty;

   assign req_tready = !q_stat.full;
   assign accept     = req_tvalid && req_tready;
   assign q_push     = accept;
   assign pb         = req_tdata[7:0];
   assign len        = req_tdata[8 +: LenW];

   always_comb begin
      crc_new  = crc_byte(inside_ff ? crc_ff : CRC_ONES, pb);
      is_empty = !inside_ff && (len == '0);

      q_entry.hdr   = !inside_ff;
      q_entry.empty = is_empty;
      q_entry.pbyte = pb;
      q_entry.len   = inside_ff ? '0 : LEN_FIELD_W'(len);
      q_entry.last  = inside_ff ? (remain_ff == LenW'(1)) : (is_empty || len == LenW'(1));
      q_entry.crc   = is_empty ? CRC_ONES : crc_new;

      inside_in = inside_ff;
      remain_in = remain_ff;
      crc_in    = crc_ff;
      if (accept) begin
         crc_in = crc_new;
         if (!inside_ff) begin
            inside_in = !is_empty && (len != LenW'(1));
            remain_in = len - LenW'(1);
         end else begin
            inside_in = (remain_ff != LenW'(1));
            remain_in = remain_ff - LenW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff <= 1'b0;
      end else begin
         inside_ff <= inside_in;
      end
      remain_ff <= remain_in;
      crc_ff    <= crc_in;
   end

endmodule

>>> rtl/rfmc_queue.sv
// Short entry queue between front and back end.
module rfmc_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  rfmc_pkg::entry_type   push_entry,
   input  logic                  pop,
   output rfmc_pkg::entry_type   head,
   output rfmc_pkg::qstat_type   stat
);
   import rfmc_pkg::*;

   localparam int PtrW = $clog2(Q_DEPTH);
   localparam int CntW = $clog2(Q_DEPTH + 1);

   entry_type       mem_ff [Q_DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign head       = mem_ff[rd_ptr_ff];
   assign stat.full  = (count_ff == CntW'(Q_DEPTH));
   assign stat.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PtrW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PtrW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CntW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> rtl/rfmc_back.sv
// Back end: byte sequencer that emits length, length CRC, payload and data CRC bytes.
module rfmc_back (
   input  logic                  clock,
   input  logic                  reset,
   input  rfmc_pkg::qstat_type   q_stat,
   input  rfmc_pkg::entry_type   q_head,
   output logic                  q_pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,
   output logic                  rsp_tlast,
   output logic                  rsp_tuser
);
   import rfmc_pkg::*;

   localparam logic [4:0] STEP_LEN0  = 5'd0;
   localparam logic [4:0] STEP_LCRC0 = 5'd8;
   localparam logic [4:0] STEP_LCRC3 = 5'd11;
   localparam logic [4:0] STEP_PAY   = 5'd12;
   localparam logic [4:0] STEP_DCRC0 = 5'd13;
   localparam logic [4:0] STEP_END   = 5'd16;

   entry_type   cur_ff, cur_in;
   logic        cur_valid_ff, cur_valid_in;
   logic [4:0]  step_ff, step_in;
   logic [31:0] lcrc_ff, lcrc_in;
   logic        out_valid_ff, out_valid_in;
   logic [7:0]  out_byte_ff, out_byte_in;
   logic        out_eor_ff, out_eor_in;
   logic        out_eoi_ff, out_eoi_in;

   logic        advance;
   logic        done;
   logic        done_now;
   logic [63:0] len64;
   logic [31:0] msk;
   logic [4:0]  dsel;
   logic [4:0]  step_next;
   logic [7:0]  byte_sel;
   logic        eor_sel;
   logic        eoi_sel;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tlast  = out_eor_ff;
   assign rsp_tuser  = out_eoi_ff;

   always_comb begin
      advance  = cur_valid_ff && (!out_valid_ff || rsp_tready);
      len64    = {{(64 - LEN_FIELD_W){1'b0}}, cur_ff.len};
      msk      = mask_crc((step_ff < STEP_PAY) ? lcrc_ff : cur_ff.crc);
      dsel     = step_ff - STEP_DCRC0;
      byte_sel = '0;
      eor_sel  = 1'b0;
      eoi_sel  = 1'b0;
      done     = 1'b0;
      step_next = step_ff + 5'd1;
      if (step_ff < STEP_LCRC0) begin
         byte_sel = len64[{step_ff[2:0], 3'b000} +: 8];
      end else if (step_ff < STEP_PAY) begin
         byte_sel = msk[{step_ff[1:0], 3'b000} +: 8];
         if (step_ff == STEP_LCRC3 && cur_ff.empty) begin
            step_next = STEP_DCRC0;
         end
      end else if (step_ff == STEP_PAY) begin
         byte_sel = cur_ff.pbyte;
         eoi_sel  = !cur_ff.last;
         done     = !cur_ff.last;
      end else begin
         byte_sel = msk[{dsel[1:0], 3'b000} +: 8];
         eor_sel  = (step_ff == STEP_END);
         eoi_sel  = (step_ff == STEP_END);
         done     = (step_ff == STEP_END);
      end

      done_now = advance && done;
      q_pop    = (!cur_valid_ff || done_now) && !q_stat.empty;

      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      step_in      = step_ff;
      lcrc_in      = lcrc_ff;
      if (advance) begin
         step_in = step_next;
         if (step_ff < STEP_LCRC0) begin
            lcrc_in = crc_byte(lcrc_ff, byte_sel);
         end
      end
      if (q_pop) begin
         cur_in       = q_head;
         cur_valid_in = 1'b1;
         step_in      = q_head.hdr ? STEP_LEN0 : STEP_PAY;
         lcrc_in      = CRC_ONES;
      end else if (done_now) begin
         cur_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_eor_in   = out_eor_ff;
      out_eoi_in   = out_eoi_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_byte_in  = byte_sel;
         out_eor_in   = eor_sel;
         out_eoi_in   = eoi_sel;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         out_valid_ff <= out_valid_in;
      end
      cur_ff      <= cur_in;
      step_ff     <= step_in;
      lcrc_ff     <= lcrc_in;
      out_byte_ff <= out_byte_in;
      out_eor_ff  <= out_eor_in;
      out_eoi_ff  <= out_eoi_in;
   end

endmodule

>>> tb/tb_record_framer_masked_crc32c_core.sv
// Self-checking testbench for the record framer with masked CRC32C length and data checks.
module tb_record_framer_masked_crc32c_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int MAX_REPORTED  = 10;
   localparam int SETTLE_CYCLES = 20;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       end_rec;
      logic       end_item;
   } frame_byte_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;   // [7:0] payload_byte, [39:8] record_length
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;   // [7:0] out_byte
   logic        rsp_tlast;   // end_of_record
   logic        rsp_tuser;   // [0] end_of_item

   frame_byte_type framed_stream[$];
   frame_byte_type want;

   logic        in_record;
   logic [31:0] bytes_left;
   logic [31:0] payload_crc;

   int send_idle_pct;
   int recv_stall_pct;
   int requests_sent;
   int bytes_seen;
   int mismatch_count;
   int cycle_count;

   record_framer_masked_crc32c_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   function automatic logic [31:0] crc32c_update(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] r;
      r = crc;
      for (int i = 0; i < 8; i++) begin
         if (r[0] ^ b[i]) begin
            r = (r >> 1) ^ rfmc_pkg::CRC_POLY;
         end else begin
            r = r >> 1;
         end
      end
      return r;
   endfunction

   function automatic logic [31:0] masked_crc(input logic [31:0] raw);
      logic [31:0] inv;
      inv = raw ^ rfmc_pkg::CRC_ONES;
      return ((inv >> 15) | (inv << 17)) + rfmc_pkg::MASK_DELTA;
   endfunction

   function automatic void emit_byte(input logic [7:0] b, input logic eor);
      frame_byte_type e;
      e.out_byte = b;
      e.end_rec  = eor;
      e.end_item = 1'b0;
      framed_stream.insert(framed_stream.size(), e);
   endfunction

   function automatic void emit_crc(input logic [31:0] value, input logic is_data);
      for (int i = 0; i < 4; i++) begin
         emit_byte(value[8*i +: 8], is_data && (i == 3));
      end
   endfunction

   function automatic void predict_framing(input logic [7:0] pb, input logic [31:0] len);
      logic [63:0]    prefix;
      logic [31:0]    len_crc;
      if (!in_record) begin
         prefix  = {32'd0, len};
         len_crc = rfmc_pkg::CRC_ONES;
         for (int i = 0; i < 8; i++) begin
            len_crc = crc32c_update(len_crc, prefix[8*i +: 8]);
            emit_byte(prefix[8*i +: 8], 1'b0);
         end
         emit_crc(masked_crc(len_crc), 1'b0);
         payload_crc = rfmc_pkg::CRC_ONES;
         if (len == 32'd0) begin
            emit_crc(masked_crc(payload_crc), 1'b1);
         end else begin
            payload_crc = crc32c_update(payload_crc, pb);
            emit_byte(pb, 1'b0);
            bytes_left = len - 32'd1;
            if (bytes_left == 32'd0) begin
               emit_crc(masked_crc(payload_crc), 1'b1);
            end else begin
               in_record = 1'b1;
            end
         end
      end else begin
         payload_crc = crc32c_update(payload_crc, pb);
         emit_byte(pb, 1'b0);
         bytes_left = bytes_left - 32'd1;
         if (bytes_left == 32'd0) begin
            emit_crc(masked_crc(payload_crc), 1'b1);
            in_record = 1'b0;
         end
      end
      framed_stream[framed_stream.size() - 1].end_item = 1'b1;
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (framed_stream.size() == 0) begin
            mismatch_count = mismatch_count + 1;
            if (mismatch_count <= MAX_REPORTED) begin
               $display("unexpected output byte %02h (eor %0b eoi %0b) at result %0d",
                        rsp_tdata, rsp_tlast, rsp_tuser, bytes_seen);
            end
         end else begin
            want = framed_stream.pop_front();
            if (want.out_byte !== rsp_tdata || want.end_rec !== rsp_tlast ||
                want.end_item !== rsp_tuser) begin
               mismatch_count = mismatch_count + 1;
               if (mismatch_count <= MAX_REPORTED) begin
                  $display("result %0d: expected byte %02h eor %0b eoi %0b, got %02h %0b %0b",
                           bytes_seen, want.out_byte, want.end_rec, want.end_item,
                           rsp_tdata, rsp_tlast, rsp_tuser);
               end
            end
         end
         bytes_seen = bytes_seen + 1;
      end
   end

   task automatic send_request(input logic [7:0] pb, input logic [31:0] len);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {len, pb};
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      predict_framing(pb, len);
      requests_sent = requests_sent + 1;
   endtask

   task automatic wait_for_drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (framed_stream.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // later requests of a record carry a random, ignored length field
   task automatic send_record(input logic [31:0] len);
      send_request(8'($urandom_range(255)), len);
      for (longint unsigned i = 1; i < len; i++) begin
         send_request(8'($urandom_range(255)), $urandom());
      end
   endtask

   function automatic logic [31:0] pick_length();
      int r;
      r = $urandom_range(99);
      if (r < 15) return 32'd0;
      if (r < 35) return 32'd1;
      if (r < 85) return $urandom_range(12, 2);
      if (r < 99) return $urandom_range(64, 13);
      return $urandom_range(300, 256);
   endfunction

   task automatic run_random_traffic(input int target);
      int start;
      start = requests_sent;
      while (requests_sent - start < target) begin
         send_record(pick_length());
      end
      wait_for_drain();
   endtask

   task automatic test_directed();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      send_request(8'hFF, 32'd0);
      send_request(8'h00, 32'd0);
      send_request(8'h00, 32'd1);
      send_request(8'hFF, 32'd1);
      send_request(8'hA5, 32'd2);
      send_request(8'h5A, 32'hFFFF_FFFF);
      send_request(8'h00, 32'd5);
      send_request(8'hFF, 32'd0);
      send_request(8'h80, 32'hFFFF_FFFF);
      send_request(8'h01, 32'd0);
      send_request(8'h7F, 32'd7);
      wait_for_drain();
   endtask

   task automatic test_random_no_idle();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      run_random_traffic(30);
   endtask

   task automatic test_random_sender_idle();
      send_idle_pct  = 60;
      recv_stall_pct = 0;
      run_random_traffic(30);
   endtask

   task automatic test_random_receiver_stall();
      send_idle_pct  = 0;
      recv_stall_pct = 60;
      run_random_traffic(30);
   endtask

   task automatic test_random_both_idle();
      send_idle_pct  = 18;
      recv_stall_pct = 18;
      run_random_traffic(30);
   endtask

   // leave a maximum-length record open for the rest of the run
   task automatic test_open_record();
      send_idle_pct  = 18;
      recv_stall_pct = 18;
      send_request(8'($urandom_range(255)), 32'hFFFF_FFFF);
      repeat (20) send_request(8'($urandom_range(255)), $urandom());
      wait_for_drain();
   endtask

   initial begin
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      rsp_tready     = 1'b0;
      in_record      = 1'b0;
      bytes_left     = '0;
      payload_crc    = rfmc_pkg::CRC_ONES;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      requests_sent  = 0;
      bytes_seen     = 0;
      mismatch_count = 0;
      cycle_count    = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_random_no_idle();
      test_random_sender_idle();
      test_random_receiver_stall();
      test_random_both_idle();
      test_open_record();

      recv_stall_pct = 0;
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && framed_stream.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

>>> record_framer_masked_crc32c_core.f
rtl/rfmc_pkg.sv
rtl/rfmc_front.sv
rtl/rfmc_queue.sv
rtl/rfmc_back.sv
rtl/record_framer_masked_crc32c_core.sv
tb/tb_record_framer_masked_crc32c_core.sv
